FILE: src/znfr_pkg.sv
package znfr_pkg;

   // Largest frame accepted; a declared total above it ends the frame as too long.
   localparam int MAX_FRAME = 256;
   // Start byte, length byte, two command bytes and the check byte.
   localparam int FRAME_OVERHEAD = 5;
   // Largest total that the length byte can declare.
   localparam int MAX_DECLARED = 255 + FRAME_OVERHEAD;
   localparam int COUNT_TOP = (MAX_FRAME > MAX_DECLARED) ? MAX_FRAME : MAX_DECLARED;
   localparam int COUNT_W = $clog2(COUNT_TOP + 1);

   localparam int LENGTH_W = 9;
   localparam int INDEX_W = 8;
   localparam int TIMEOUT_W = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_BYTE  = 2'd1,
      OP_TICK  = 2'd2,
      OP_NONE  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_VALID      = 3'd0,
      ST_EMPTY      = 3'd1,
      ST_INCOMPLETE = 3'd2,
      ST_BADFCS     = 3'd3,
      ST_TOOLONG    = 3'd4
   } status_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [7:0]            rx_byte;
      logic [TIMEOUT_W-1:0]  session_tmo;
   } req_item_type;

   typedef struct packed {
      logic                  byte_valid;
      logic [7:0]            data_byte;
      logic [INDEX_W-1:0]    byte_index;
      logic                  frame_done;
      status_type            frame_status;
      logic [LENGTH_W-1:0]   frame_length;
   } rsp_item_type;

   typedef struct packed {
      logic                  valid;
      rsp_item_type          item;
   } rsp_beat_type;

endpackage

FILE: src/znfr_engine.sv
module znfr_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  znfr_pkg::req_item_type item,
   output znfr_pkg::rsp_beat_type beat
);
   import znfr_pkg::*;

   logic                  active_ff, active_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [COUNT_W-1:0]    expected_ff, expected_in;
   logic [7:0]            xor_ff, xor_in;
   logic [TIMEOUT_W-1:0]  elapsed_ff, elapsed_in;
   logic [TIMEOUT_W-1:0]  limit_ff, limit_in;

   logic [COUNT_W-1:0]    count_next;
   logic [COUNT_W-1:0]    declared;
   logic [COUNT_W-1:0]    expected_now;
   logic [TIMEOUT_W-1:0]  elapsed_next;
   logic                  last_byte;
   logic                  too_long;

   assign count_next   = count_ff + COUNT_W'(1);
   assign declared     = {{(COUNT_W-8){1'b0}}, item.rx_byte} + COUNT_W'(FRAME_OVERHEAD);
   assign expected_now = (count_ff == COUNT_W'(1)) ? declared : expected_ff;
   assign last_byte    = count_next >= expected_now;
   assign too_long     = expected_now > COUNT_W'(MAX_FRAME);
   assign elapsed_next = (elapsed_ff == {TIMEOUT_W{1'b1}}) ? elapsed_ff
                                                            : elapsed_ff + TIMEOUT_W'(1);

   always_comb begin
      active_in   = active_ff;
      count_in    = count_ff;
      expected_in = expected_ff;
      xor_in      = xor_ff;
      elapsed_in  = elapsed_ff;
      limit_in    = limit_ff;
      beat        = '0;
      if (step) begin
         unique case (item.opcode)
            OP_START: begin
               active_in   = 1'b1;
               count_in    = '0;
               expected_in = COUNT_W'(MAX_FRAME);
               xor_in      = '0;
               elapsed_in  = '0;
               limit_in    = item.session_tmo;
            end
            OP_BYTE: begin
               if (active_ff) begin
                  expected_in          = expected_now;
                  count_in             = count_next;
                  beat.valid           = 1'b1;
                  beat.item.byte_valid = 1'b1;
                  beat.item.data_byte  = item.rx_byte;
                  beat.item.byte_index = count_ff[INDEX_W-1:0];
                  if (too_long) begin
                     beat.item.frame_done   = 1'b1;
                     beat.item.frame_status = ST_TOOLONG;
                  end else if (last_byte) begin
                     beat.item.frame_done   = 1'b1;
                     beat.item.frame_status = (xor_ff == item.rx_byte) ? ST_VALID : ST_BADFCS;
                  end else if (count_ff != '0) begin
                     xor_in = xor_ff ^ item.rx_byte;
                  end
                  if (beat.item.frame_done) begin
                     active_in              = 1'b0;
                     beat.item.frame_length = count_next[LENGTH_W-1:0];
                  end
               end
            end
            OP_TICK: begin
               if (active_ff) begin
                  elapsed_in = elapsed_next;
                  if (elapsed_next >= limit_ff) begin
                     active_in              = 1'b0;
                     beat.valid             = 1'b1;
                     beat.item.frame_done   = 1'b1;
                     beat.item.frame_status = (count_ff == '0) ? ST_EMPTY : ST_INCOMPLETE;
                     beat.item.frame_length = count_ff[LENGTH_W-1:0];
                  end
               end
            end
            OP_NONE: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         count_ff    <= '0;
         expected_ff <= COUNT_W'(MAX_FRAME);
         xor_ff      <= '0;
         elapsed_ff  <= '0;
         limit_ff    <= '0;
      end else begin
         active_ff   <= active_in;
         count_ff    <= count_in;
         expected_ff <= expected_in;
         xor_ff      <= xor_in;
         elapsed_ff  <= elapsed_in;
         limit_ff    <= limit_in;
      end
   end

endmodule

FILE: src/znfr_out_buf.sv
module znfr_out_buf (
   input  logic                   clock,
   input  logic                   reset,
   input  znfr_pkg::rsp_beat_type push,
   output logic                   push_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output znfr_pkg::rsp_item_type out_item
);
   import znfr_pkg::*;

   logic         main_valid_ff;
   logic         skid_valid_ff;
   rsp_item_type main_item_ff;
   rsp_item_type skid_item_ff;

   // Ready depends on the skid stage alone, so it does not follow out_ready.
   assign push_ready = !skid_valid_ff;
   assign out_valid  = main_valid_ff;
   assign out_item   = main_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!main_valid_ff || out_ready) begin
         main_valid_ff <= skid_valid_ff || push.valid;
         skid_valid_ff <= 1'b0;
      end else if (push.valid) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!main_valid_ff || out_ready) begin
         main_item_ff <= skid_valid_ff ? skid_item_ff : push.item;
      end else if (push.valid && !skid_valid_ff) begin
         skid_item_ff <= push.item;
      end
   end

endmodule

FILE: src/znp_frame_receiver_with_timeout_core.sv
// A transferred request is loaded into the input register; the engine's result for it is
// then loaded into the result register, or into the skid stage while the result register
// still holds an earlier result. Throughput: one request per cycle while the result buffer
// has room, set by the single-pass update of the session counters.
// Reset (synchronous, active high) closes any session, clears the counters and empties
// both the input register and the result buffer.
module znp_frame_receiver_with_timeout_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [znfr_pkg::REQ_DATA_W-1:0] req_tdata,   // rx_byte[7:0], session_tmo[23:8]
   input  logic [1:0]                      req_tuser,   // opcode[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [znfr_pkg::RSP_DATA_W-1:0] rsp_tdata,   // data_byte[7:0], byte_index[15:8],
                                    // frame_status[18:16], frame_length[27:19], zero[31:28]
   output logic [0:0]                      rsp_tuser,   // byte_valid[0]
   output logic                            rsp_tlast    // frame_done
);
   import znfr_pkg::*;

   // Input register. It advances whenever the result buffer can take what the engine
   // produces, so a request is taken in every cycle while the downstream side keeps up.
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         buf_ready;
   logic         advance;
   rsp_beat_type beat;
   rsp_item_type out_item;

   assign advance    = in_valid_ff && buf_ready;
   assign req_tready = !in_valid_ff || buf_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_item_ff.opcode      <= opcode_type'(req_tuser);
         in_item_ff.rx_byte     <= req_tdata[7:0];
         in_item_ff.session_tmo <= req_tdata[23:8];
      end
   end

   // The engine holds the session state and forms at most one result per request.
   znfr_engine u_engine (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .beat  (beat)
   );

   // Result register with a skid stage, so that a stalled result does not stop the
   // request side until the skid stage is full as well.
   znfr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (beat),
      .push_ready (buf_ready),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_item   (out_item)
   );

   assign rsp_tdata = {4'b0000, out_item.frame_length, out_item.frame_status,
                       out_item.byte_index, out_item.data_byte};
   assign rsp_tuser = out_item.byte_valid;
   assign rsp_tlast = out_item.frame_done;

   // A result that echoes no byte can only be the end of a session.
   a_tick_result_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("result without byte echo is not a frame end");

   // Status and length are zero on a result that does not end the session.
   a_status_only_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[27:16] == 12'd0)
      else $error("status or length set on a result that is not a frame end");

   // A request held in the input register is not lost while the buffer is full.
   a_input_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !buf_ready |=> in_valid_ff && $stable(in_item_ff))
      else $error("stalled request dropped or changed");

   // The engine produces a result only when the buffer has room for it.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      beat.valid |-> buf_ready)
      else $error("result pushed into a full buffer");

endmodule
